/* rtl/core/utf8_stream_decoder_macros.svh */
// Assertion macros used by the decoder top level.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UTF8D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8 decoder: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define UTF8D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8 decoder: next-cycle check failed");

`endif

/* rtl/core/utf8d_pkg.sv */
// Types and constants shared by the UTF-8 stream decoder modules.
package utf8d_pkg;

    localparam int unsigned CP_W = 21;
    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    localparam logic [7:0] MASK_CONT   = 8'hC0;
    localparam logic [7:0] MASK_LEAD2  = 8'hE0;
    localparam logic [7:0] MASK_LEAD3  = 8'hF0;
    localparam logic [7:0] MASK_LEAD4  = 8'hF8;
    localparam logic [7:0] CODE_CONT   = 8'h80;
    localparam logic [7:0] CODE_LEAD2  = 8'hC0;
    localparam logic [7:0] CODE_LEAD3  = 8'hE0;
    localparam logic [7:0] CODE_LEAD4  = 8'hF0;
    localparam logic [7:0] MASK_PAYLD  = 8'h3F;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } byte_item_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            last_of_run;
    } cp_item_t;

    // One decoded byte: pre_count replacements, an optional main result,
    // then replacements up to total results.
    typedef struct packed {
        logic [1:0]      pre_count;
        logic            main_valid;
        logic [CP_W-1:0] main_cp;
        logic            main_rep;
        logic [2:0]      total;
    } cmd_t;

endpackage

/* rtl/core/utf8_stream_decoder.sv */
// Top level of the lenient streaming UTF-8 decoder.
// The decoder takes one byte per cycle and gives one code point result per cycle; a byte's
// command is registered in the queue and each result in the output register. A byte that
// completes a character, or an ASCII or bad lead byte, gives one result; a byte that opens
// or extends a sequence gives none; an interrupted sequence or end of text gives one
// replacement per held byte, up to four results for one byte, given one per output cycle.
// The front decodes each byte combinationally and hands a command to a four-entry queue; the
// back expands commands at one result per cycle, so byte_stall rises only when the queue
// fills, either under bursts of replacements or while cp_stall holds the output. Each
// byte_valid/byte_stall transaction moves one byte, and each cp_valid/cp_stall transaction
// moves one result, with last_of_run set on the last result caused by a byte.
`include "utf8_stream_decoder_macros.svh"

module utf8_stream_decoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  utf8d_pkg::byte_item_t byte_item,
    output logic                 cp_valid,
    input  logic                 cp_stall,
    output utf8d_pkg::cp_item_t  cp_item
);

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    utf8d_pkg::cmd_t push_cmd;
    utf8d_pkg::cmd_t head_cmd;

    utf8d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .queue_full (full),
        .push       (push),
        .cmd        (push_cmd)
    );

    utf8d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (empty)
    );

    utf8d_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .empty    (empty),
        .pop      (pop),
        .cp_valid (cp_valid),
        .cp_stall (cp_stall),
        .cp_item  (cp_item)
    );

    `UTF8D_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !full || pop)
    `UTF8D_ASSERT_NEXT(a_pop_gives_last, clk, rst_n, pop, cp_valid && cp_item.last_of_run)
    `UTF8D_ASSERT_NEXT(a_run_continues, clk, rst_n, cp_valid && !cp_stall && !cp_item.last_of_run, cp_valid)

endmodule

/* rtl/core/utf8d_front.sv */
// Front part: accepts bytes, tracks the open sequence and builds result commands.
module utf8d_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  utf8d_pkg::byte_item_t byte_item,
    input  logic                 queue_full,
    output logic                 push,
    output utf8d_pkg::cmd_t      cmd
);

    logic [utf8d_pkg::CP_W-1:0] acc_reg, acc_next;
    logic [2:0]                 needed_reg, needed_next;
    logic [1:0]                 held_reg, held_next;
    logic                       accept;
    logic [7:0]                 b;
    logic                       is_cont;
    logic [1:0]                 post_count;

    assign b          = byte_item.text_byte;
    assign is_cont    = (b & utf8d_pkg::MASK_CONT) == utf8d_pkg::CODE_CONT;
    assign byte_stall = queue_full;
    assign accept     = byte_valid && !queue_full;

    always_comb
    begin
        acc_next        = acc_reg;
        needed_next     = needed_reg;
        held_next       = held_reg;
        cmd.pre_count   = 2'd0;
        cmd.main_valid  = 1'b0;
        cmd.main_cp     = utf8d_pkg::REPLACEMENT_CP;
        cmd.main_rep    = 1'b0;
        post_count      = 2'd0;

        if (needed_reg != 3'd0 && is_cont)
        begin
            acc_next    = {acc_reg[utf8d_pkg::CP_W-7:0], b[5:0]};
            needed_next = needed_reg - 3'd1;
            held_next   = held_reg + 2'd1;
            if (needed_reg == 3'd1)
            begin
                cmd.main_valid = 1'b1;
                cmd.main_cp    = acc_next;
                acc_next       = '0;
                held_next      = 2'd0;
            end
        end
        else
        begin
            if (needed_reg != 3'd0)
            begin
                cmd.pre_count = held_reg;
                acc_next      = '0;
                needed_next   = 3'd0;
                held_next     = 2'd0;
            end
            if (b[7] == 1'b0)
            begin
                cmd.main_valid = 1'b1;
                cmd.main_cp    = {13'd0, b};
            end
            else if ((b & utf8d_pkg::MASK_LEAD2) == utf8d_pkg::CODE_LEAD2)
            begin
                acc_next    = {16'd0, b[4:0]};
                needed_next = 3'd1;
                held_next   = 2'd1;
            end
            else if ((b & utf8d_pkg::MASK_LEAD3) == utf8d_pkg::CODE_LEAD3)
            begin
                acc_next    = {17'd0, b[3:0]};
                needed_next = 3'd2;
                held_next   = 2'd1;
            end
            else if ((b & utf8d_pkg::MASK_LEAD4) == utf8d_pkg::CODE_LEAD4)
            begin
                acc_next    = {18'd0, b[2:0]};
                needed_next = 3'd3;
                held_next   = 2'd1;
            end
            else
            begin
                cmd.main_valid = 1'b1;
                cmd.main_rep   = 1'b1;
            end
        end

        if (byte_item.end_of_text)
        begin
            post_count  = held_next;
            acc_next    = '0;
            needed_next = 3'd0;
            held_next   = 2'd0;
        end

        cmd.total = {1'b0, cmd.pre_count} + {2'b00, cmd.main_valid} + {1'b0, post_count};
    end

    assign push = accept && (cmd.total != 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            needed_reg <= 3'd0;
            held_reg   <= 2'd0;
        end
        else if (accept)
        begin
            acc_reg    <= acc_next;
            needed_reg <= needed_next;
            held_reg   <= held_next;
        end
    end

endmodule

/* rtl/core/utf8d_queue.sv */
// Command queue between the front and back parts.
module utf8d_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  utf8d_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output utf8d_pkg::cmd_t head_cmd,
    output logic            empty
);

    utf8d_pkg::cmd_t               entries [utf8d_pkg::QUEUE_DEPTH];
    logic [utf8d_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [utf8d_pkg::QUEUE_AW:0]   count_reg;

    assign full     = count_reg == (utf8d_pkg::QUEUE_AW+1)'(utf8d_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign head_cmd = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/utf8d_back.sv */
// Back part: expands each command into code point results behind an output register.
module utf8d_back (
    input  logic                clk,
    input  logic                rst_n,
    input  utf8d_pkg::cmd_t     head_cmd,
    input  logic                empty,
    output logic                pop,
    output logic                cp_valid,
    input  logic                cp_stall,
    output utf8d_pkg::cp_item_t cp_item
);

    logic [1:0]          idx_reg;
    logic                valid_reg;
    utf8d_pkg::cp_item_t item_reg;
    utf8d_pkg::cp_item_t item_next;
    logic                emit;
    logic                is_main;
    logic                is_last;

    assign emit    = !empty && (!valid_reg || !cp_stall);
    assign is_main = head_cmd.main_valid && (idx_reg == head_cmd.pre_count);
    assign is_last = {1'b0, idx_reg} == (head_cmd.total - 3'd1);
    assign pop     = emit && is_last;

    always_comb
    begin
        item_next.code_point  = is_main ? head_cmd.main_cp : utf8d_pkg::REPLACEMENT_CP;
        item_next.replaced    = is_main ? head_cmd.main_rep : 1'b1;
        item_next.last_of_run = is_last;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else if (emit)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= is_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (!cp_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    assign cp_valid = valid_reg;
    assign cp_item  = item_reg;

endmodule
